// ===== rtl/core/edge_run_height_width_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// edge_run_height_width_scanner_defines
// Assertion macros used by the scanner core.
// ----------------------------------------------------------------------------
`ifndef EDGE_RUN_HEIGHT_WIDTH_SCANNER_DEFINES_SVH
`define EDGE_RUN_HEIGHT_WIDTH_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ERHW_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ERHW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/erhw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erhw_pkg
// Types, constants and helper functions of the edge run scanner.
// ----------------------------------------------------------------------------
package erhw_pkg;

    localparam int MAX_LINE        = 4096;
    localparam int WIDTH_FIELD_MAX = 4095;

    localparam int PIXEL_W  = 8;
    localparam int HEIGHT_W = 8;
    localparam int WIDTH_W  = 12;
    localparam int PADDR_W  = 3;

    // Saturation point of the width counter
    localparam logic [WIDTH_W-1:0] COUNT_LIMIT =
        WIDTH_W'((MAX_LINE - 1 < WIDTH_FIELD_MAX) ? (MAX_LINE - 1) : WIDTH_FIELD_MAX);

    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd10;

    // Register index taken from paddr[2]
    localparam logic REG_EDGE_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RAMP    = 2'd1,
        MODE_PLATEAU = 2'd2
    } mode_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
        logic                falling;
    } result_t;

    // Decisions of the scan state machine for the datapath
    typedef struct packed {
        logic open_run;    // edge found, start a new run
        logic rise;        // direction of the new run is upward
        logic count_inc;   // pixel belongs to the run
        logic hold_prev;   // ramp ended on the previous pixel
        logic hold_last;   // line ended while on the ramp
        logic emit;        // run closes, send a result
    } ctrl_t;

    // Distance of v from base on the run's side (signed, 10 bit)
    function automatic logic signed [9:0] side_dist(
        input logic [PIXEL_W-1:0] base,
        input logic               fall,
        input logic [PIXEL_W-1:0] v
    );
        logic signed [9:0] b;
        logic signed [9:0] x;
        b = $signed({2'b00, base});
        x = $signed({2'b00, v});
        return fall ? (b - x) : (x - b);
    endfunction

    // Ramp height, clamped at zero
    function automatic logic [HEIGHT_W-1:0] ramp_height(
        input logic [PIXEL_W-1:0] base,
        input logic               fall,
        input logic [PIXEL_W-1:0] v
    );
        logic signed [9:0] d;
        d = side_dist(base, fall, v);
        return d[9] ? '0 : d[HEIGHT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/erhw_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erhw_apb_regs
// APB register file: holds the edge threshold.
// ----------------------------------------------------------------------------
module erhw_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [erhw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [erhw_pkg::PIXEL_W-1:0]  edge_threshold
);
    import erhw_pkg::*;

    logic [PIXEL_W-1:0] thr_reg;
    logic [PIXEL_W-1:0] thr_next;
    logic               wr_en;
    logic               sel_thr;

    assign pready  = 1'b1;
    assign sel_thr = (paddr[2] == REG_EDGE_THRESHOLD);
    assign wr_en   = psel & penable & pwrite & pready & sel_thr;

    // register write
    always_comb begin
        thr_next = thr_reg;
        if (wr_en) begin
            thr_next = pwdata[PIXEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else begin
            thr_reg <= thr_next;
        end
    end

    // read back; addresses with paddr[2] set read zero
    assign prdata = sel_thr ? {{(32-PIXEL_W){1'b0}}, thr_reg} : 32'd0;

    assign edge_threshold = thr_reg;

endmodule

// ===== rtl/core/erhw_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erhw_core
// Input register, scan state machine and run datapath.
// ----------------------------------------------------------------------------
module erhw_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [erhw_pkg::PIXEL_W-1:0] edge_threshold,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [erhw_pkg::PIXEL_W-1:0] in_pixel,
    input  logic                         in_line_start,
    input  logic                         in_line_end,
    input  logic                         res_ready,
    output logic                         res_valid,
    output erhw_pkg::result_t            res
);
    import erhw_pkg::*;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               ls_reg;
    logic               le_reg;

    // scan state
    mode_t               mode_reg, mode_next;
    logic [PIXEL_W-1:0]  prev_reg, prev_next;
    logic [PIXEL_W-1:0]  base_reg, base_next;
    logic [HEIGHT_W-1:0] held_reg, held_next;
    logic [WIDTH_W-1:0]  count_reg, count_next;
    logic                fall_reg, fall_next;

    logic              adv;
    ctrl_t             ctrl;
    mode_t             mode_mid;
    logic signed [9:0] thr_s;
    logic              on_side;
    logic              up_edge;
    logic              dn_edge;
    logic              ramp_cont;

    assign adv      = in_valid_reg & res_ready;
    assign in_ready = ~in_valid_reg | adv;

    // input register load
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_ready) begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg <= in_pixel;
            ls_reg    <= in_line_start;
            le_reg    <= in_line_end;
        end
    end

    // compares
    assign thr_s     = $signed({2'b00, edge_threshold});
    assign on_side   = side_dist(base_reg, fall_reg, pixel_reg) > thr_s;
    assign up_edge   = side_dist(prev_reg, 1'b0, pixel_reg) > thr_s;
    assign dn_edge   = side_dist(prev_reg, 1'b1, pixel_reg) > thr_s;
    assign ramp_cont = fall_reg ? (pixel_reg < prev_reg) : (pixel_reg > prev_reg);

    // next state and control decisions
    always_comb begin
        ctrl     = '0;
        mode_mid = mode_reg;
        if (ls_reg) begin
            mode_mid = MODE_IDLE;
        end else begin
            case (mode_reg)
                MODE_RAMP: begin
                    if (ramp_cont) begin
                        ctrl.count_inc = 1'b1;
                    end else begin
                        ctrl.hold_prev = 1'b1;
                        if (on_side) begin
                            ctrl.count_inc = 1'b1;
                            mode_mid       = MODE_PLATEAU;
                        end else begin
                            ctrl.emit = 1'b1;
                            mode_mid  = MODE_IDLE;
                        end
                    end
                end
                MODE_PLATEAU: begin
                    if (on_side) begin
                        ctrl.count_inc = 1'b1;
                    end else begin
                        ctrl.emit = 1'b1;
                        mode_mid  = MODE_IDLE;
                    end
                end
                default: begin
                    mode_mid = MODE_IDLE;
                    if (up_edge || dn_edge) begin
                        ctrl.open_run = 1'b1;
                        ctrl.rise     = up_edge;
                        mode_mid      = MODE_RAMP;
                    end
                end
            endcase
        end

        // a run still open at line end is closed here
        mode_next = mode_mid;
        if (le_reg && !ls_reg && (mode_mid == MODE_RAMP || mode_mid == MODE_PLATEAU)) begin
            ctrl.hold_last = (mode_mid == MODE_RAMP);
            ctrl.emit      = 1'b1;
            mode_next      = MODE_IDLE;
        end
    end

    // datapath next values
    always_comb begin
        prev_next  = pixel_reg;
        base_next  = ctrl.open_run ? prev_reg : base_reg;
        fall_next  = ctrl.open_run ? ~ctrl.rise : fall_reg;

        count_next = count_reg;
        if (ctrl.open_run) begin
            count_next = WIDTH_W'(1);
        end else if (ctrl.count_inc && (count_reg < COUNT_LIMIT)) begin
            count_next = count_reg + WIDTH_W'(1);
        end

        held_next = held_reg;
        if (ctrl.hold_last) begin
            held_next = ramp_height(base_next, fall_next, pixel_reg);
        end else if (ctrl.hold_prev) begin
            held_next = ramp_height(base_reg, fall_reg, prev_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            prev_reg  <= '0;
            base_reg  <= '0;
            held_reg  <= '0;
            count_reg <= '0;
            fall_reg  <= 1'b0;
        end else if (adv) begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            base_reg  <= base_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            fall_reg  <= fall_next;
        end
    end

    // result toward the output register
    assign res_valid   = adv & ctrl.emit;
    assign res.height  = held_next;
    assign res.width   = count_next;
    assign res.falling = fall_next;

    `include "edge_run_height_width_scanner_defines.svh"

    `ERHW_ASSERT(a_open_run_counted, aclk, aresetn, mode_reg != MODE_IDLE, count_reg != '0, "open run with zero width")
    `ERHW_ASSERT(a_result_width, aclk, aresetn, res_valid, res.width != '0, "result with zero width")
    `ERHW_ASSERT(a_count_limit, aclk, aresetn, 1'b1, count_reg <= COUNT_LIMIT, "width counter past limit")
    `ERHW_ASSERT_NEXT(a_line_bound_idle, aclk, aresetn, adv && (ls_reg || le_reg), mode_reg == MODE_IDLE, "run open across a line boundary")

endmodule

// ===== rtl/core/erhw_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erhw_out_reg
// Result register driving the master stream channel.
// ----------------------------------------------------------------------------
module erhw_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  erhw_pkg::result_t res,
    output logic              res_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [7:0] run_height, [19:8] run_width, zero pad
    output logic [0:0]        m_tuser    // [0] run_falling
);
    import erhw_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // slot is free when empty or drained this cycle
    assign res_ready = ~valid_reg | m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.width, res_reg.height};
    assign m_tuser  = res_reg.falling;

endmodule

// ===== rtl/core/edge_run_height_width_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_run_height_width_scanner
// Measures height and width of grey-level edge runs along pixel lines.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one 8-bit pixel per transfer in s_tdata, s_tuser[0] set on
//   the first pixel of a line, s_tlast set on the last one.
//   Master channel: one transfer per closed run, m_tdata carries the run
//   height [7:0] and width [19:8], m_tuser[0] is set for a falling run.
//   A run still open at the end of a line is reported with that line's last
//   pixel; a run open when a new line starts is dropped.
//   APB: the edge threshold sits at address 0 (reset value 10). Write it only
//   while no pixels are in flight.
// Throughput and pipeline:
//   One pixel per cycle while the result register is free (empty or m_tready
//   high). The pixel that closes a run passes through the input register;
//   its result is then held in the result register that drives m_tvalid.
//   The per-pixel scan logic is a single compare-and-count step.
// Reset and stalls:
//   aresetn (synchronous) empties both registers and returns the scanner to
//   idle with a zero previous pixel. When m_tready is low the held result
//   stays put; one more pixel can be taken into the input register, then
//   s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module edge_run_height_width_scanner (
    input  logic                         aclk,
    input  logic                         aresetn,
    // slave stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel
    input  logic [0:0]                   s_tuser,   // [0] line_start
    input  logic                         s_tlast,   // line_end
    // master stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [7:0] run_height, [19:8] run_width
    output logic [0:0]                   m_tuser,   // [0] run_falling
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [erhw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import erhw_pkg::*;

    logic [PIXEL_W-1:0] edge_threshold;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    erhw_apb_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .edge_threshold (edge_threshold)
    );

    erhw_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .edge_threshold (edge_threshold),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_pixel       (s_tdata),
        .in_line_start  (s_tuser[0]),
        .in_line_end    (s_tlast),
        .res_ready      (res_ready),
        .res_valid      (res_valid),
        .res            (res)
    );

    erhw_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
